FILE: rtl/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int CODE_W = 16;
	localparam int AGE_W  = 8;
	localparam int WORD_W = CODE_W + AGE_W;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_SERVED   = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic              operation;
		logic [CODE_W-1:0] entry_code;
		logic [AGE_W-1:0]  entry_age;
		logic              high_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [CODE_W-1:0] served_code;
		logic [AGE_W-1:0]  served_age;
		logic              served_high;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_ENQ_LOW  = 2'd0,
		CMD_ENQ_HIGH = 2'd1,
		CMD_DEQ      = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [WORD_W-1:0] word;
	} cmd_t;

	// Handshake between the front and the back.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage

FILE: rtl/tcpq_ram.sv
`timescale 1ns / 1ps

module tcpq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/tcpq_front.sv
`timescale 1ns / 1ps

module tcpq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tcpq_pkg::req_t     request,
	output tcpq_pkg::cmd_chan_t cmd_chan,
	input  logic               cmd_take
);

	import tcpq_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_in;
	logic       accept;
	logic       take;

	// Classify the request so the back only has to look at one code.
	always_comb begin
		cmd_in.word = {request.entry_code, request.entry_age};
		if (request.operation == OP_DEQUEUE) begin
			cmd_in.kind = CMD_DEQ;
		end else if (request.high_priority) begin
			cmd_in.kind = CMD_ENQ_HIGH;
		end else begin
			cmd_in.kind = CMD_ENQ_LOW;
		end
	end

	assign full   = (cnt_q == 2'd2);
	assign accept = push && !full;
	assign take   = cmd_take && (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, accept} - {1'b0, take};
		end
	end

	assign cmd_chan.valid = (cnt_q != 2'd0);
	assign cmd_chan.cmd   = slot_q[rd_ptr_q];

endmodule

FILE: rtl/tcpq_back.sv
`timescale 1ns / 1ps

module tcpq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tcpq_pkg::cmd_chan_t cmd_chan,
	output logic                cmd_take,
	output logic                empty,
	input  logic                pop,
	output tcpq_pkg::rsp_t      result
);

	import tcpq_pkg::*;

	typedef enum logic [1:0] {
		S_RUN  = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   sel_high_q;
	logic   sel_high_d;

	logic [PTR_W-1:0] hi_head_q, hi_tail_q, lo_head_q, lo_tail_q;
	logic [CNT_W-1:0] hi_cnt_q, lo_cnt_q;

	logic             hi_we, lo_we, hi_re, lo_re;
	logic [WORD_W-1:0] hi_rdata, lo_rdata, rd_word;

	rsp_t       res_q [2];
	logic       res_wr_q;
	logic       res_rd_q;
	logic [1:0] res_cnt_q;
	logic       res_push;
	rsp_t       res_in;
	logic       res_pop;
	logic       room;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	tcpq_ram #(.WIDTH(WORD_W), .DEPTH(QUEUE_DEPTH)) u_high_ram (
		.clk   (clk),
		.we    (hi_we),
		.waddr (hi_tail_q),
		.wdata (cmd_chan.cmd.word),
		.re    (hi_re),
		.raddr (hi_head_q),
		.rdata (hi_rdata)
	);

	tcpq_ram #(.WIDTH(WORD_W), .DEPTH(QUEUE_DEPTH)) u_low_ram (
		.clk   (clk),
		.we    (lo_we),
		.waddr (lo_tail_q),
		.wdata (cmd_chan.cmd.word),
		.re    (lo_re),
		.raddr (lo_head_q),
		.rdata (lo_rdata)
	);

	// The result queue never fills behind a pending read, because the read
	// is only started when a slot is free and nothing else is pushed meanwhile.
	assign room     = (res_cnt_q != 2'd2);
	assign cmd_take = (state_q == S_RUN) && cmd_chan.valid && room;
	assign rd_word  = sel_high_q ? hi_rdata : lo_rdata;

	always_comb begin
		state_d    = state_q;
		sel_high_d = sel_high_q;
		hi_we      = 1'b0;
		lo_we      = 1'b0;
		hi_re      = 1'b0;
		lo_re      = 1'b0;
		res_push   = 1'b0;
		res_in     = '0;
		case (state_q)
			S_RUN: begin
				if (cmd_take) begin
					case (cmd_chan.cmd.kind)
						CMD_ENQ_HIGH: begin
							res_push = 1'b1;
							if (hi_cnt_q == CNT_W'(QUEUE_DEPTH)) begin
								res_in.status = ST_FULL;
							end else begin
								hi_we         = 1'b1;
								res_in.status = ST_ENQUEUED;
							end
						end
						CMD_ENQ_LOW: begin
							res_push = 1'b1;
							if (lo_cnt_q == CNT_W'(QUEUE_DEPTH)) begin
								res_in.status = ST_FULL;
							end else begin
								lo_we         = 1'b1;
								res_in.status = ST_ENQUEUED;
							end
						end
						CMD_DEQ: begin
							if (hi_cnt_q != '0) begin
								hi_re      = 1'b1;
								sel_high_d = 1'b1;
								state_d    = S_READ;
							end else if (lo_cnt_q != '0) begin
								lo_re      = 1'b1;
								sel_high_d = 1'b0;
								state_d    = S_READ;
							end else begin
								res_push      = 1'b1;
								res_in.status = ST_EMPTY;
							end
						end
						default: begin
							res_push      = 1'b1;
							res_in.status = ST_EMPTY;
						end
					endcase
				end
			end
			S_READ: begin
				res_push           = 1'b1;
				res_in.status      = ST_SERVED;
				res_in.served_code = rd_word[WORD_W-1:AGE_W];
				res_in.served_age  = rd_word[AGE_W-1:0];
				res_in.served_high = sel_high_q;
				state_d            = S_RUN;
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_RUN;
			sel_high_q <= 1'b0;
			hi_head_q  <= '0;
			hi_tail_q  <= '0;
			hi_cnt_q   <= '0;
			lo_head_q  <= '0;
			lo_tail_q  <= '0;
			lo_cnt_q   <= '0;
		end else begin
			state_q    <= state_d;
			sel_high_q <= sel_high_d;
			if (hi_we) begin
				hi_tail_q <= next_ptr(hi_tail_q);
				hi_cnt_q  <= hi_cnt_q + CNT_W'(1);
			end else if (hi_re) begin
				hi_head_q <= next_ptr(hi_head_q);
				hi_cnt_q  <= hi_cnt_q - CNT_W'(1);
			end
			if (lo_we) begin
				lo_tail_q <= next_ptr(lo_tail_q);
				lo_cnt_q  <= lo_cnt_q + CNT_W'(1);
			end else if (lo_re) begin
				lo_head_q <= next_ptr(lo_head_q);
				lo_cnt_q  <= lo_cnt_q - CNT_W'(1);
			end
		end
	end

	assign empty   = (res_cnt_q == 2'd0);
	assign res_pop = pop && !empty;
	assign result  = res_q[res_rd_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wr_q <= ~res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= ~res_rd_q;
			end
			res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

endmodule

FILE: rtl/two_class_priority_queue_unit.sv
`timescale 1ns / 1ps

// Two-class strict priority queue. Each request either enqueues an entry
// (code, age, class) or dequeues one; every request yields exactly one
// result. A dequeue serves the oldest high-class entry if any is held, else
// the oldest low-class entry; each class holds QUEUE_DEPTH entries and an
// enqueue to a full class is rejected with status full. A two-entry request
// queue decouples the input from the executing back end, which owns one RAM
// per class and a two-entry result queue. The back end completes an enqueue,
// a rejected enqueue or an empty dequeue directly, and a serving dequeue
// via a read state because of the registered RAM read; each request passes
// the registered request and result queues before its result is visible.
module two_class_priority_queue_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tcpq_pkg::req_t request,
	output logic           empty,
	input  logic           pop,
	output tcpq_pkg::rsp_t result
);

	import tcpq_pkg::*;

	cmd_chan_t cmd_chan;
	logic      cmd_take;

	tcpq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.cmd_chan (cmd_chan),
		.cmd_take (cmd_take)
	);

	tcpq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_chan (cmd_chan),
		.cmd_take (cmd_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
